// ===== hdl/krt_pkg.sv =====
// Package for the keyed record table: field widths, function and status codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package krt_pkg;

	localparam int FUNC_W   = 2;
	localparam int KEY_W    = 16;
	localparam int SAL_W    = 32;
	localparam int STAT_W   = 3;
	localparam int TOT_W    = 36;
	localparam int ENT_W    = 5;
	localparam int REC_W    = KEY_W + SAL_W;

	localparam int LIST_LIMIT = 16;
	localparam int LCNT_W     = $clog2(LIST_LIMIT);

	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_FIND   = 2'd2;
	localparam logic [FUNC_W-1:0] FN_LIST   = 2'd3;

	localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
	localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

	typedef struct packed {
		logic              load;       // capture request beat
		logic              idx_top;    // index to newest record
		logic              idx_inc;
		logic              idx_dec;
		logic              rd;         // read record at index
		logic              hit_cap;    // result regs from read data
		logic              res_clr;    // result regs to zero
		logic              wr_ins;     // write request record at occupancy
		logic              wr_shift;   // write read data one slot down
		logic              commit_ins;
		logic              commit_rem;
		logic              emit;       // load output register
		logic              emit_rd;    // emit read data rather than result regs
		logic              emit_last;
		logic [STAT_W-1:0] status;
	} krt_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              occ_zero;
		logic              full;
		logic              rd_match;
		logic              idx_zero;
		logic              idx_top;
		logic              list_cap;
		logic              out_free;
	} krt_sts_t;

endpackage

// ===== hdl/krt_if.sv =====
// Valid/ready channel interfaces for request and result beats.
// Depends on krt_pkg.
interface krt_req_if import krt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [KEY_W-1:0]  key;
	logic [SAL_W-1:0]  salary;

	modport source (output valid, func, key, salary, input ready);
	modport sink (input valid, func, key, salary, output ready);
endinterface

interface krt_res_if import krt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [KEY_W-1:0]  found_key;
	logic [SAL_W-1:0]  found_salary;
	logic [TOT_W-1:0]  total_salary;
	logic [ENT_W-1:0]  entries;
	logic              last;

	modport source (output valid, status, found_key, found_salary, total_salary, entries,
		last, input ready);
	modport sink (input valid, status, found_key, found_salary, total_salary, entries,
		last, output ready);
endinterface

// ===== hdl/krt_ctrl.sv =====
// Controller for the keyed record table: sequences search, gap closing and
// listing by commands to the datapath. Depends on krt_pkg.
module krt_ctrl import krt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  krt_sts_t sts,
	output krt_cmd_t cmd
);

	typedef enum logic [3:0] {
		IDLE, START, SRCH_RD, SRCH_CMP, MISS, SHIFT_RD, SHIFT_WR, REM_COMMIT,
		LIST_RD, LIST_EMIT, EMIT
	} state_t;

	state_t            state_q, state_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic              list_last;

	assign req_ready = (state_q == IDLE);
	assign list_last = sts.idx_zero || sts.list_cap;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		status_d = status_q;
		unique case (state_q)
			IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = START;
				end
			end
			START: begin
				if (sts.func == FN_LIST) begin
					if (sts.occ_zero) begin
						cmd.res_clr = 1'b1;
						status_d    = ST_EMPTY;
						state_d     = EMIT;
					end else begin
						cmd.idx_top = 1'b1;
						state_d     = LIST_RD;
					end
				end else if (sts.occ_zero) begin
					state_d = MISS;
				end else begin
					cmd.idx_top = 1'b1;
					state_d     = SRCH_RD;
				end
			end
			SRCH_RD: begin
				cmd.rd  = 1'b1;
				state_d = SRCH_CMP;
			end
			SRCH_CMP: begin
				if (sts.rd_match) begin
					if (sts.func == FN_INSERT) begin
						cmd.res_clr = 1'b1;
						status_d    = ST_DUP;
						state_d     = EMIT;
					end else if (sts.func == FN_REMOVE) begin
						cmd.hit_cap = 1'b1;
						if (sts.idx_top) begin
							state_d = REM_COMMIT;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = SHIFT_RD;
						end
					end else begin
						cmd.hit_cap = 1'b1;
						status_d    = ST_DONE;
						state_d     = EMIT;
					end
				end else if (sts.idx_zero) begin
					state_d = MISS;
				end else begin
					cmd.idx_dec = 1'b1;
					state_d     = SRCH_RD;
				end
			end
			MISS: begin
				cmd.res_clr = 1'b1;
				state_d     = EMIT;
				if (sts.func != FN_INSERT) begin
					status_d = ST_NOTFOUND;
				end else if (sts.full) begin
					status_d = ST_FULL;
				end else begin
					cmd.wr_ins     = 1'b1;
					cmd.commit_ins = 1'b1;
					status_d       = ST_DONE;
				end
			end
			SHIFT_RD: begin
				cmd.rd  = 1'b1;
				state_d = SHIFT_WR;
			end
			SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				if (sts.idx_top) begin
					state_d = REM_COMMIT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = SHIFT_RD;
				end
			end
			REM_COMMIT: begin
				cmd.commit_rem = 1'b1;
				status_d       = ST_DONE;
				state_d        = EMIT;
			end
			LIST_RD: begin
				cmd.rd  = 1'b1;
				state_d = LIST_EMIT;
			end
			LIST_EMIT: begin
				cmd.status = ST_DONE;
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_rd   = 1'b1;
					cmd.emit_last = list_last;
					if (list_last) begin
						state_d = IDLE;
					end else begin
						cmd.idx_dec = 1'b1;
						state_d     = LIST_RD;
					end
				end
			end
			EMIT: begin
				cmd.status = status_q;
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					state_d       = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			status_q <= ST_DONE;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

endmodule

// ===== hdl/krt_dp.sv =====
// Datapath for the keyed record table: record memory, index and count
// registers, running total and output register. Depends on krt_pkg.
module krt_dp import krt_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	krt_req_if.sink  req,
	krt_res_if.source res,
	input  krt_cmd_t cmd,
	output krt_sts_t sts
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [REC_W-1:0]  mem [DEPTH];
	logic [REC_W-1:0]  rd_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     wr_addr;
	logic [CW-1:0]     occ_q;
	logic [TOT_W-1:0]  total_q;
	logic [LCNT_W-1:0] lcnt_q;
	logic [FUNC_W-1:0] func_q;
	logic [KEY_W-1:0]  key_q;
	logic [SAL_W-1:0]  sal_q;
	logic [KEY_W-1:0]  res_key_q;
	logic [SAL_W-1:0]  res_sal_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [SAL_W-1:0]  out_sal_q;
	logic [TOT_W-1:0]  out_total_q;
	logic [ENT_W-1:0]  out_ent_q;
	logic              out_last_q;
	logic [KEY_W-1:0]  rd_key;
	logic [SAL_W-1:0]  rd_sal;

	assign rd_key = rd_q[REC_W-1 -: KEY_W];
	assign rd_sal = rd_q[SAL_W-1:0];

	assign sts.func     = func_q;
	assign sts.occ_zero = (occ_q == '0);
	assign sts.full     = (occ_q == CW'(DEPTH));
	assign sts.rd_match = (rd_key == key_q);
	assign sts.idx_zero = (idx_q == '0);
	assign sts.idx_top  = ((CW'(idx_q) + CW'(1)) == occ_q);
	assign sts.list_cap = (lcnt_q == LCNT_W'(LIST_LIMIT - 1));
	assign sts.out_free = !out_valid_q || res.ready;

	assign wr_addr = cmd.wr_ins ? AW'(occ_q) : AW'(idx_q - AW'(1));

	always_ff @(posedge clk) begin
		if (cmd.wr_ins) begin
			mem[wr_addr] <= {key_q, sal_q};
		end else if (cmd.wr_shift) begin
			mem[wr_addr] <= rd_q;
		end
		if (cmd.rd) begin
			rd_q <= mem[idx_q];
		end
	end

	// request and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= req.func;
			key_q  <= req.key;
			sal_q  <= req.salary;
			lcnt_q <= '0;
		end else if (cmd.emit && cmd.emit_rd) begin
			lcnt_q <= lcnt_q + LCNT_W'(1);
		end
		if (cmd.idx_top) begin
			idx_q <= AW'(occ_q - CW'(1));
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - AW'(1);
		end
		if (cmd.res_clr) begin
			res_key_q <= '0;
			res_sal_q <= '0;
		end else if (cmd.hit_cap) begin
			res_key_q <= rd_key;
			res_sal_q <= rd_sal;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			total_q <= '0;
		end else if (cmd.commit_ins) begin
			occ_q   <= occ_q + CW'(1);
			total_q <= total_q + TOT_W'(sal_q);
		end else if (cmd.commit_rem) begin
			occ_q   <= occ_q - CW'(1);
			total_q <= total_q - TOT_W'(res_sal_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= cmd.status;
			out_key_q    <= cmd.emit_rd ? rd_key : res_key_q;
			out_sal_q    <= cmd.emit_rd ? rd_sal : res_sal_q;
			out_total_q  <= total_q;
			out_ent_q    <= ENT_W'(occ_q);
			out_last_q   <= cmd.emit_last;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.status       = out_status_q;
	assign res.found_key    = out_key_q;
	assign res.found_salary = out_sal_q;
	assign res.total_salary = out_total_q;
	assign res.entries      = out_ent_q;
	assign res.last         = out_last_q;

`ifndef SYNTH
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy beyond depth");
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_ins |-> !sts.full)
		else $error("insert into full table");
	a_rem_some: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_rem |-> !sts.occ_zero)
		else $error("remove from empty table");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result beat overwritten");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_ins |-> !cmd.wr_shift)
		else $error("two writes in one cycle");
`endif

endmodule

// ===== hdl/keyed_record_table_top.sv =====
// Top level of the keyed record table: controller and datapath joined by
// command and status structs. Depends on krt_pkg, krt_if, krt_ctrl, krt_dp.
//
// Use: one request beat on req (func, key, salary) gives one result beat on
// res, or for a list one beat per stored record, newest first, at most 16,
// with last set on the final one. An empty list gives one beat, status empty.
// Every result carries the record count and salary total after the request.
// One request is worked at a time; req.ready is high only while idle.
// Sequence: a request searches the stored records from newest to oldest,
// reading and comparing each and stopping at a hit; an insert of a new key,
// or a remove or find of an absent key, examines all of them. A remove hit
// then shifts each newer record one slot down, read then write, and commits.
// A list reads and emits each record in turn. The memory is single-port.
// Results pass through an output register: a stalled receiver holds the
// current beat and pauses a list; a new request may be taken while a result
// waits. Reset clears count, total and output valid; the record memory needs
// no clearing pass, as only slots below the count are ever read.
module keyed_record_table_top import krt_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	krt_req_if.sink   req,
	krt_res_if.source res
);

	krt_cmd_t cmd;
	krt_sts_t sts;

	krt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	krt_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule
